### src/ccs_pkg.sv
// Shared types and character constants for the comment stripper.
// Used by the lexer, the result queue and the top level; no dependencies.
package ccs_pkg;

  localparam int CHAR_W     = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_LINE   = 4'b0010,
    MODE_BLOCK  = 4'b0100,
    MODE_QUOTED = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              fin;
  } item_t;

  typedef struct packed {
    logic [1:0] cnt;
    item_t      first;
    item_t      second;
  } result_t;

endpackage

### src/ccs_lexer.sv
// Lexer state and per-byte step: turns one accepted byte into zero, one or two items.
// Depends on ccs_pkg.
module ccs_lexer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      fire,
  input  logic [ccs_pkg::CHAR_W-1:0] chr,
  input  logic                      last,
  output ccs_pkg::result_t          res
);

  ccs_pkg::mode_t mode_r, mode_nxt;
  logic           single_r, single_nxt;
  logic           escape_r, escape_nxt;
  logic           star_r, star_nxt;
  logic           held_r, held_nxt;

  logic [ccs_pkg::CHAR_W-1:0] c0, c1;
  logic [1:0]                 n;
  logic                       is_quote;

  always_comb begin
    mode_nxt   = mode_r;
    single_nxt = single_r;
    escape_nxt = escape_r;
    star_nxt   = star_r;
    held_nxt   = held_r;
    c0         = ccs_pkg::CH_SPACE;
    c1         = ccs_pkg::CH_SPACE;
    n          = 2'd0;
    is_quote   = (chr == ccs_pkg::CH_DQUOTE) || (chr == ccs_pkg::CH_SQUOTE);
    case (mode_r)
      ccs_pkg::MODE_LINE: begin
        n = 2'd1;
        if (chr == ccs_pkg::CH_NL) begin
          mode_nxt = ccs_pkg::MODE_NORMAL;
          c0       = ccs_pkg::CH_NL;
        end
      end
      ccs_pkg::MODE_BLOCK: begin
        n = 2'd1;
        if (star_r && chr == ccs_pkg::CH_SLASH) begin
          mode_nxt = ccs_pkg::MODE_NORMAL;
          star_nxt = 1'b0;
        end else begin
          c0       = (chr == ccs_pkg::CH_NL) ? ccs_pkg::CH_NL : ccs_pkg::CH_SPACE;
          star_nxt = (chr == ccs_pkg::CH_STAR);
        end
      end
      ccs_pkg::MODE_QUOTED: begin
        n  = 2'd1;
        c0 = chr;
        if (escape_r) begin
          escape_nxt = 1'b0;
        end else if (chr == ccs_pkg::CH_BSLASH) begin
          escape_nxt = 1'b1;
        end else if (chr == (single_r ? ccs_pkg::CH_SQUOTE : ccs_pkg::CH_DQUOTE)) begin
          mode_nxt = ccs_pkg::MODE_NORMAL;
        end
      end
      default: begin
        if (held_r && (chr == ccs_pkg::CH_SLASH || chr == ccs_pkg::CH_STAR)) begin
          held_nxt = 1'b0;
          mode_nxt = (chr == ccs_pkg::CH_SLASH) ? ccs_pkg::MODE_LINE : ccs_pkg::MODE_BLOCK;
          star_nxt = 1'b0;
          n        = 2'd2;
        end else begin
          held_nxt = 1'b0;
          if (chr == ccs_pkg::CH_SLASH && !last) begin
            held_nxt = 1'b1;
          end else if (is_quote) begin
            mode_nxt   = ccs_pkg::MODE_QUOTED;
            single_nxt = (chr == ccs_pkg::CH_SQUOTE);
            escape_nxt = 1'b0;
          end
          if (held_r) begin
            c0 = ccs_pkg::CH_SLASH;
            c1 = chr;
            n  = (chr == ccs_pkg::CH_SLASH && !last) ? 2'd1 : 2'd2;
          end else begin
            c0 = chr;
            n  = (chr == ccs_pkg::CH_SLASH && !last) ? 2'd0 : 2'd1;
          end
        end
      end
    endcase
    if (last) begin
      mode_nxt   = ccs_pkg::MODE_NORMAL;
      single_nxt = 1'b0;
      escape_nxt = 1'b0;
      star_nxt   = 1'b0;
      held_nxt   = 1'b0;
    end
    res.cnt          = n;
    res.first.chr    = c0;
    res.first.fin    = last && (n == 2'd1);
    res.second.chr   = c1;
    res.second.fin   = last && (n == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ccs_pkg::MODE_NORMAL;
      single_r <= 1'b0;
      escape_r <= 1'b0;
      star_r   <= 1'b0;
      held_r   <= 1'b0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      single_r <= single_nxt;
      escape_r <= escape_nxt;
      star_r   <= star_nxt;
      held_r   <= held_nxt;
    end
  end

endmodule

### src/ccs_outq.sv
// Result queue: takes up to two items a cycle, gives one a cycle on the output channel while rd_ready is high.
// Depends on ccs_pkg.
module ccs_outq #(
  parameter int DEPTH = ccs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  ccs_pkg::result_t wr_res,
  output logic             room,
  output logic             rd_valid,
  input  logic             rd_ready,
  output ccs_pkg::item_t   rd_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ccs_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       n_wr;
  logic             rd_fire;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic [PTR_W-1:0] wr_ptr_p2;
  logic [PTR_W-1:0] rd_ptr_p1;

  assign n_wr      = wr_en ? wr_res.cnt : 2'd0;
  assign rd_valid  = (count_r != '0);
  assign rd_fire   = rd_valid && rd_ready;
  assign rd_item   = mem[rd_ptr_r];
  assign room      = (count_r <= CNT_W'(DEPTH - 2));
  assign wr_ptr_p1 = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
  assign wr_ptr_p2 = (wr_ptr_p1 == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_p1 + PTR_W'(1);
  assign rd_ptr_p1 = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);

  always_comb begin
    case (n_wr)
      2'd1: wr_ptr_nxt = wr_ptr_p1;
      2'd2: wr_ptr_nxt = wr_ptr_p2;
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = rd_fire ? rd_ptr_p1 : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(n_wr) - CNT_W'(rd_fire);
  end

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      mem[wr_ptr_r] <= wr_res.first;
    end
    if (n_wr == 2'd2) begin
      mem[wr_ptr_p1] <= wr_res.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### src/c_comment_stripper_top.sv
// Top level of the comment stripper: lexer step feeding the result queue.
// Depends on ccs_pkg, ccs_lexer and ccs_outq.
//
// Channel  Direction  tdata           tlast
// in_      slave      char_in[7:0]    end_of_source
// out_     master     char_out[7:0]   final_out
//
// One byte is taken per cycle while in_tready is high; its items enter the queue
// at the accepting edge and appear on out_ from the following cycle, one per cycle
// while out_tready is high. A two-item byte grows the queue by one only if an item
// leaves; in_tready drops only with under two slots free, which needs output stalls.
// rst_n (synchronous) returns the lexer to normal code and empties the queue.
module c_comment_stripper_top #(
  parameter int QUEUE_DEPTH = ccs_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_in
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] char_out
  output logic       out_tlast
);

  logic             in_fire;
  ccs_pkg::result_t res;
  ccs_pkg::item_t   head;

  assign in_fire = in_tvalid && in_tready;

  ccs_lexer u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .chr   (in_tdata),
    .last  (in_tlast),
    .res   (res)
  );

  ccs_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_fire),
    .wr_res   (res),
    .room     (in_tready),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_item  (head)
  );

  assign out_tdata = head.chr;
  assign out_tlast = head.fin;

endmodule

### src/ccs_checker.sv
// Port-level checker for the comment stripper, bound to the top level.
// Depends on c_comment_stripper_top's ports only.
module ccs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output item changed");

  a_final_yields: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast && !out_tvalid |=> out_tvalid)
    else $error("final byte gave no item");

  a_stall_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with nothing queued");

endmodule

bind c_comment_stripper_top ccs_checker u_ccs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### test/tb_c_comment_stripper_top.sv
`timescale 1ns / 100ps
// Self-checking bench for c_comment_stripper_top: directed byte table, then random C-like sources.
// Depends on ccs_pkg and the stripper RTL; predicts every output item in step with the input stream.
module tb_c_comment_stripper_top;

  typedef struct packed {
    logic [7:0]       chr;
    logic             eos;
    logic             typed;
    ccs_pkg::result_t want;
  } dir_row_t;

  localparam ccs_pkg::item_t NO_ITEM = '{8'h00, 1'b0};
  localparam ccs_pkg::item_t SP_ITEM = '{ccs_pkg::CH_SPACE, 1'b0};
  localparam int PHASE_ITEMS = 400;

  localparam dir_row_t DIR_ROWS [26] = '{
    '{8'h00,              1'b0, 1'b1, '{2'd1, '{8'h00, 1'b0}, NO_ITEM}},
    '{8'hFF,              1'b0, 1'b1, '{2'd1, '{8'hFF, 1'b0}, NO_ITEM}},
    '{ccs_pkg::CH_SLASH,  1'b1, 1'b1, '{2'd1, '{ccs_pkg::CH_SLASH, 1'b1}, NO_ITEM}},
    '{ccs_pkg::CH_SLASH,  1'b0, 1'b1, '{2'd0, NO_ITEM, NO_ITEM}},
    '{ccs_pkg::CH_SLASH,  1'b0, 1'b1, '{2'd2, SP_ITEM, SP_ITEM}},
    '{ccs_pkg::CH_NL,     1'b0, 1'b0, '0},
    '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, '0},
    '{ccs_pkg::CH_STAR,   1'b0, 1'b0, '0},
    '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, '0},
    '{ccs_pkg::CH_STAR,   1'b0, 1'b0, '0},
    '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, '0},
    '{ccs_pkg::CH_DQUOTE, 1'b0, 1'b0, '0},
    '{ccs_pkg::CH_SQUOTE, 1'b0, 1'b0, '0},
    '{ccs_pkg::CH_BSLASH, 1'b0, 1'b0, '0},
    '{ccs_pkg::CH_DQUOTE, 1'b0, 1'b0, '0},
    '{ccs_pkg::CH_DQUOTE, 1'b0, 1'b0, '0},
    '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, '0},
    '{8'h78,              1'b0, 1'b0, '0},
    '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, '0},
    '{ccs_pkg::CH_SLASH,  1'b1, 1'b0, '0},
    '{ccs_pkg::CH_SQUOTE, 1'b0, 1'b0, '0},
    '{ccs_pkg::CH_BSLASH, 1'b1, 1'b0, '0},
    '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, '0},
    '{ccs_pkg::CH_STAR,   1'b0, 1'b0, '0},
    '{8'h80,              1'b1, 1'b0, '0},
    '{ccs_pkg::CH_SLASH,  1'b0, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  int phase = 0;
  int tx_idle [3] = '{19, 88, 0};
  int rx_idle [3] = '{88, 19, 0};
  int errors = 0;

  ccs_pkg::item_t expected_items[$];
  logic [7:0]     src_q[$];

  ccs_pkg::mode_t   lex_state = ccs_pkg::MODE_NORMAL;
  logic             in_char_lit = 1'b0;
  logic             escape_next = 1'b0;
  logic             star_prev = 1'b0;
  logic             slash_wait = 1'b0;
  ccs_pkg::result_t stripped;

  c_comment_stripper_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void emit_char(input logic [7:0] c);
    if (stripped.cnt == 2'd0) stripped.first.chr = c;
    else stripped.second.chr = c;
    stripped.cnt = stripped.cnt + 2'd1;
  endfunction

  function automatic void plain_code(input logic [7:0] c, input logic eos);
    if (c == ccs_pkg::CH_SLASH) begin
      if (eos) emit_char(c);
      else slash_wait = 1'b1;
    end else begin
      if (c == ccs_pkg::CH_DQUOTE || c == ccs_pkg::CH_SQUOTE) begin
        lex_state   = ccs_pkg::MODE_QUOTED;
        in_char_lit = (c == ccs_pkg::CH_SQUOTE);
        escape_next = 1'b0;
      end
      emit_char(c);
    end
  endfunction

  function automatic void strip_byte(input logic [7:0] c, input logic eos);
    stripped = '0;
    case (lex_state)
      ccs_pkg::MODE_LINE: begin
        if (c == ccs_pkg::CH_NL) begin
          lex_state = ccs_pkg::MODE_NORMAL;
          emit_char(ccs_pkg::CH_NL);
        end else begin
          emit_char(ccs_pkg::CH_SPACE);
        end
      end
      ccs_pkg::MODE_BLOCK: begin
        if (star_prev && c == ccs_pkg::CH_SLASH) begin
          lex_state = ccs_pkg::MODE_NORMAL;
          star_prev = 1'b0;
          emit_char(ccs_pkg::CH_SPACE);
        end else begin
          emit_char(c == ccs_pkg::CH_NL ? ccs_pkg::CH_NL : ccs_pkg::CH_SPACE);
          star_prev = (c == ccs_pkg::CH_STAR);
        end
      end
      ccs_pkg::MODE_QUOTED: begin
        emit_char(c);
        if (escape_next) escape_next = 1'b0;
        else if (c == ccs_pkg::CH_BSLASH) escape_next = 1'b1;
        else if (c == (in_char_lit ? ccs_pkg::CH_SQUOTE : ccs_pkg::CH_DQUOTE))
          lex_state = ccs_pkg::MODE_NORMAL;
      end
      default: begin
        if (slash_wait) begin
          slash_wait = 1'b0;
          if (c == ccs_pkg::CH_SLASH || c == ccs_pkg::CH_STAR) begin
            lex_state = (c == ccs_pkg::CH_SLASH) ? ccs_pkg::MODE_LINE : ccs_pkg::MODE_BLOCK;
            star_prev = 1'b0;
            emit_char(ccs_pkg::CH_SPACE);
            emit_char(ccs_pkg::CH_SPACE);
          end else begin
            emit_char(ccs_pkg::CH_SLASH);
            plain_code(c, eos);
          end
        end else begin
          plain_code(c, eos);
        end
      end
    endcase
    if (eos) begin
      if (stripped.cnt == 2'd2) stripped.second.fin = 1'b1;
      else if (stripped.cnt == 2'd1) stripped.first.fin = 1'b1;
      lex_state   = ccs_pkg::MODE_NORMAL;
      in_char_lit = 1'b0;
      escape_next = 1'b0;
      star_prev   = 1'b0;
      slash_wait  = 1'b0;
    end
  endfunction

  function automatic logic [7:0] comment_char();
    case ($urandom_range(0, 5))
      0: return ccs_pkg::CH_STAR;
      1: return ccs_pkg::CH_SLASH;
      2: return ccs_pkg::CH_NL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_src(input logic [7:0] c);
    src_q = {src_q, c};
  endfunction

  task automatic build_source();
    int target;
    src_q.delete();
    target = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
    while (src_q.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_src(8'($urandom_range(8'h21, 8'h7E)));
        3: begin
          add_src(ccs_pkg::CH_SLASH);
          add_src(ccs_pkg::CH_SLASH);
          repeat ($urandom_range(0, 8)) add_src(comment_char());
          add_src(ccs_pkg::CH_NL);
        end
        4: begin
          add_src(ccs_pkg::CH_SLASH);
          add_src(ccs_pkg::CH_STAR);
          repeat ($urandom_range(0, 10)) add_src(comment_char());
          add_src(ccs_pkg::CH_STAR);
          add_src(ccs_pkg::CH_SLASH);
        end
        5: begin
          add_src(ccs_pkg::CH_DQUOTE);
          repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 4) == 0) begin
              add_src(ccs_pkg::CH_BSLASH);
              add_src($urandom_range(0, 3) == 0 ? ccs_pkg::CH_DQUOTE
                                                : 8'($urandom_range(0, 255)));
            end else begin
              add_src(8'($urandom_range(8'h20, 8'h7E)));
            end
          end
          add_src(ccs_pkg::CH_DQUOTE);
        end
        6: begin
          add_src(ccs_pkg::CH_SQUOTE);
          if ($urandom_range(0, 2) == 0) add_src(ccs_pkg::CH_BSLASH);
          add_src(8'($urandom_range(0, 255)));
          add_src(ccs_pkg::CH_SQUOTE);
        end
        7: begin
          add_src(ccs_pkg::CH_SLASH);
          add_src(8'($urandom_range(8'h20, 8'h7E)));
        end
        8: add_src(ccs_pkg::CH_NL);
        default: add_src(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic send_byte(input logic [7:0] c, input logic eos, input logic typed,
                           input ccs_pkg::result_t typed_res);
    ccs_pkg::result_t r;
    while ($urandom_range(0, 99) < tx_idle[phase]) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    strip_byte(c, eos);
    r = typed ? typed_res : stripped;
    for (int i = 0; i < r.cnt; i++) begin
      if (i == 0) expected_items = {expected_items, r.first};
      else expected_items = {expected_items, r.second};
    end
  endtask

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= 50) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    ccs_pkg::item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_items.size() == 0) begin
        flag_mismatch($sformatf("unexpected item char_out=%h final_out=%b", out_tdata, out_tlast));
      end else begin
        want = expected_items.pop_front();
        if (out_tdata !== want.chr)
          flag_mismatch($sformatf("char_out got %h want %h", out_tdata, want.chr));
        if (out_tlast !== want.fin)
          flag_mismatch($sformatf("final_out got %b want %b (char %h)", out_tlast, want.fin,
                                  want.chr));
      end
    end
    out_tready <= ($urandom_range(0, 99) >= rx_idle[phase]);
  end

  initial begin
    int sent;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < $size(DIR_ROWS); i++)
      send_byte(DIR_ROWS[i].chr, DIR_ROWS[i].eos, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    // close the directed part with a held slash followed by a final plain byte
    send_byte(8'h71, 1'b1, 1'b0, '0);
    for (int p = 0; p < 3; p++) begin
      phase <= p;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_source();
        for (int k = 0; k < src_q.size(); k++)
          send_byte(src_q[k], k == src_q.size() - 1, 1'b0, '0);
        sent += src_q.size();
      end
    end
    in_tvalid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
